FILE: hw/rtl/sliding_window_peak_trough_detector_assert.svh
// assertion macros used by the detector top level
`ifndef SLIDING_WINDOW_PEAK_TROUGH_DETECTOR_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_TROUGH_DETECTOR_ASSERT_SVH

// consequent checked in the same cycle
`define SWPTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SWPTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swptd_pkg.sv
package swptd_pkg;

    // operation codes
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_PEAK         = 3'd0;
    localparam logic [2:0] KIND_TROUGH       = 3'd1;
    localparam logic [2:0] KIND_PEAK_REPL    = 3'd2;
    localparam logic [2:0] KIND_TROUGH_REPL  = 3'd3;
    localparam logic [2:0] KIND_STATS        = 3'd4;

    // register map
    localparam logic [2:0] REG_WINDOW_STEPS  = 3'd0;
    localparam logic [6:0] WINDOW_STEPS_RST  = 7'd64;

    // divider widths
    localparam int DIVIDEND_BITS = 64;
    localparam int DIVISOR_BITS  = 32;

    // scan outcome from the window store
    typedef struct packed {
        logic        done;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] center;
    } scan_result_t;

endpackage

FILE: hw/rtl/swptd_window.sv
module swptd_window #(
    parameter int DEPTH     = 65,
    parameter int DATA_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_BITS-1:0]       wr_data,
    input  logic                       scan_start,
    input  logic [$clog2(DEPTH)-1:0]   scan_head,
    input  logic [$clog2(DEPTH)-1:0]   scan_fill,
    input  logic [$clog2(DEPTH)-1:0]   scan_off,
    output swptd_pkg::scan_result_t    scan_res
);

    localparam int AddrW = $clog2(DEPTH);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 busy_reg;
    logic                 rd_valid_reg;
    logic [AddrW-1:0]     ptr_reg;
    logic [AddrW-1:0]     issue_cnt_reg;
    logic [AddrW-1:0]     rd_idx_reg;
    logic [AddrW-1:0]     fill_reg;
    logic [AddrW-1:0]     off_reg;
    logic [31:0]          lo_reg;
    logic [31:0]          hi_reg;
    logic [31:0]          center_reg;
    logic                 done_reg;
    logic                 rd_en;
    logic [31:0]          rd_word;

    assign rd_en   = busy_reg && (issue_cnt_reg != fill_reg);
    assign rd_word = 32'(rd_data_reg);

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    // walk from the newest entry backwards, tracking min, max and centre
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            ptr_reg       <= '0;
            issue_cnt_reg <= '0;
            rd_idx_reg    <= '0;
            fill_reg      <= '0;
            off_reg       <= '0;
            done_reg      <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            center_reg    <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            rd_valid_reg <= rd_en;
            rd_idx_reg   <= issue_cnt_reg;
            if (scan_start)
            begin
                busy_reg      <= 1'b1;
                issue_cnt_reg <= '0;
                fill_reg      <= scan_fill;
                off_reg       <= scan_off;
                ptr_reg       <= (scan_head == '0) ? AddrW'(DEPTH - 1) : scan_head - 1'b1;
            end
            else if (rd_en)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
                ptr_reg       <= (ptr_reg == '0) ? AddrW'(DEPTH - 1) : ptr_reg - 1'b1;
            end
            if (rd_valid_reg)
            begin
                if (rd_idx_reg == '0)
                begin
                    lo_reg <= rd_word;
                    hi_reg <= rd_word;
                end
                else
                begin
                    if (rd_word < lo_reg)
                    begin
                        lo_reg <= rd_word;
                    end
                    if (rd_word > hi_reg)
                    begin
                        hi_reg <= rd_word;
                    end
                end
                if (rd_idx_reg == off_reg)
                begin
                    center_reg <= rd_word;
                end
                if (rd_idx_reg == fill_reg - 1'b1)
                begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign scan_res.done   = done_reg;
    assign scan_res.lo     = lo_reg;
    assign scan_res.hi     = hi_reg;
    assign scan_res.center = center_reg;

endmodule

FILE: hw/rtl/swptd_div.sv
module swptd_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [swptd_pkg::DIVIDEND_BITS-1:0]  dividend,
    input  logic [swptd_pkg::DIVISOR_BITS-1:0]   divisor,
    output logic                                 done,
    output logic [swptd_pkg::DIVIDEND_BITS-1:0]  quotient
);

    localparam int NumW = swptd_pkg::DIVIDEND_BITS;
    localparam int DenW = swptd_pkg::DIVISOR_BITS;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] quot_reg;
    logic [DenW-1:0] rem_reg;
    logic [DenW-1:0] den_reg;
    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DenW:0]   rem_shift;
    logic [DenW:0]   rem_sub;
    logic            fits;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, quot_reg[NumW-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NumW);
                quot_reg <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                quot_reg <= {quot_reg[NumW-2:0], fits};
                rem_reg  <= fits ? rem_sub[DenW-1:0] : rem_shift[DenW-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: hw/rtl/sliding_window_peak_trough_detector.sv
// Peak and trough detector over a sliding window of one sample channel.
// Input channel (in_valid/in_ready): op selects push of a sample or finish.
// Output channel (out_valid/out_ready): crit points and, on finish, one
// statistics result; last marks the final result of each input transfer.
// window_steps is written through the APB port at offset 0; the user must
// write it only while idle, the block itself does not enforce this.
// A push that tests its centre reads the window out of the sample memory one
// entry a cycle and offers its result once the scan is done; the next transfer
// is taken once that result is registered. A push with too little history
// makes no test and frees the input at once.
// A finish drains the window: each removal runs one such scan, then the
// statistics use a shared bit-serial divider for up to three divisions.
// The output register frees the input side: a new transfer is taken while a
// result still waits; a stalled receiver holds further results back.
// Reset clears all channel state and sets window_steps to 64; the sample
// memory needs no clearing, only entries already written are ever read.
module sliding_window_peak_trough_detector #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [31:0] crit_step,
    output logic [31:0] crit_value,
    output logic signed [31:0] amplitude,
    output logic [31:0] period,
    output logic        amp_valid,
    output logic        period_valid,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int Depth     = MAX_WINDOW + 1;
    localparam int FillW     = $clog2(Depth);
    localparam int StoreBits = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_START,
        ST_SCAN_WAIT,
        ST_EVAL,
        ST_DRAIN,
        ST_DIV_P,
        ST_DIV_T,
        ST_DIV_S,
        ST_STATS
    } state_t;

    state_t        state_reg;
    logic [6:0]    window_steps_reg;
    logic [FillW-1:0] head_reg;
    logic [FillW-1:0] fill_reg;
    logic [31:0]   step_count_reg;
    logic          have_crit_reg;
    logic          last_is_peak_reg;
    logic [31:0]   last_value_reg;
    logic [31:0]   last_two0_reg;
    logic [31:0]   last_two1_reg;
    logic [31:0]   first_two0_reg;
    logic [31:0]   first_two1_reg;
    logic [63:0]   peak_sum_reg;
    logic [63:0]   trough_sum_reg;
    logic [31:0]   kept_p_reg;
    logic [31:0]   kept_t_reg;
    logic [31:0]   kept_all_reg;
    logic          finish_reg;
    logic [FillW:0] lag_reg;
    logic [32:0]   time_reg;
    logic [63:0]   qp_reg;
    logic [63:0]   qt_reg;
    logic [31:0]   period_q_reg;
    logic          div_go_reg;
    logic          out_valid_reg;
    logic [2:0]    kind_reg;
    logic [31:0]   crit_step_reg;
    logic [31:0]   crit_value_reg;
    logic [31:0]   amplitude_reg;
    logic [31:0]   period_reg;
    logic          amp_valid_reg;
    logic          period_valid_reg;
    logic          last_reg;

    logic [31:0]      cfg_wide;
    logic [31:0]      r_wide;
    logic [FillW-1:0] r_eff;
    logic [FillW-1:0] half;
    logic [FillW-1:0] fill_clip;
    logic [FillW:0]   fill_inc;
    logic [FillW-1:0] fill_push;
    logic [FillW-1:0] head_next;
    logic [FillW:0]   off_raw;
    logic [FillW-1:0] fill_m1;
    logic [FillW-1:0] scan_off;
    logic             scan_start;
    logic             in_xfer;
    logic             out_free;
    logic             cfg_write;
    swptd_pkg::scan_result_t scan_res;

    logic [31:0]  cval;
    logic         is_peak;
    logic         is_trough;
    logic         same_kind;
    logic         wider;
    logic         do_emit;
    logic [31:0]  stp;
    logic [63:0]  sum_sel;
    logic [63:0]  sum_base;
    logic [64:0]  sum_add;
    logic [63:0]  sum_new;
    logic [31:0]  cnt_sel;
    logic [31:0]  cnt_new;
    logic [31:0]  all_new;
    logic         av;
    logic         pv;
    logic [33:0]  span;
    logic [32:0]  span_pos;
    logic [63:0]  div_num;
    logic [31:0]  div_den;
    logic         div_done;
    logic [63:0]  div_q;
    logic [63:0]  mean_diff;
    logic [63:0]  mean_adj;

    // effective window length, clamped
    assign cfg_wide = 32'(window_steps_reg);
    assign r_wide   = (cfg_wide < 32'd2) ? 32'd2 :
                      ((cfg_wide > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : cfg_wide);
    assign r_eff    = r_wide[FillW-1:0];
    assign half     = r_eff >> 1;

    // fill and head after a push
    assign fill_clip = (fill_reg > r_eff) ? r_eff : fill_reg;
    assign fill_inc  = {1'b0, fill_clip} + 1'b1;
    assign fill_push = (fill_inc > {1'b0, r_eff}) ? r_eff : fill_inc[FillW-1:0];
    assign head_next = (head_reg == FillW'(Depth - 1)) ? '0 : head_reg + 1'b1;

    // centre offset, half a window behind the current time, kept inside the fill
    assign off_raw  = ({1'b0, half} >= lag_reg) ? ({1'b0, half} - lag_reg) : '0;
    assign fill_m1  = fill_reg - 1'b1;
    assign scan_off = (off_raw > {1'b0, fill_m1}) ? fill_m1 : off_raw[FillW-1:0];

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign scan_start = (state_reg == ST_SCAN_START);
    assign cfg_write  = psel && penable && pwrite && pready;

    swptd_window #(
        .DEPTH     (Depth),
        .DATA_BITS (StoreBits)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_xfer && (op == swptd_pkg::OP_PUSH)),
        .wr_addr    (head_reg),
        .wr_data    (sample[StoreBits-1:0]),
        .scan_start (scan_start),
        .scan_head  (head_reg),
        .scan_fill  (fill_reg),
        .scan_off   (scan_off),
        .scan_res   (scan_res)
    );

    // crit point classification and bookkeeping
    assign cval      = scan_res.center;
    assign is_peak   = (cval == scan_res.hi) && (cval != scan_res.lo);
    assign is_trough = (cval == scan_res.lo);
    assign same_kind = have_crit_reg && (last_is_peak_reg == is_peak);
    assign wider     = is_peak ? (cval >= last_value_reg) : (cval <= last_value_reg);
    assign do_emit   = (is_peak || is_trough) && (!same_kind || wider);
    assign stp       = (time_reg >= 33'(half)) ? 32'(time_reg - 33'(half)) : 32'd0;
    assign sum_sel   = is_peak ? peak_sum_reg : trough_sum_reg;
    assign sum_base  = same_kind ? (sum_sel - 64'(last_value_reg)) : sum_sel;
    assign sum_add   = {1'b0, sum_base} + 65'(cval);
    assign sum_new   = sum_add[64] ? '1 : sum_add[63:0];
    assign cnt_sel   = is_peak ? kept_p_reg : kept_t_reg;
    assign cnt_new   = (cnt_sel == '1) ? cnt_sel : cnt_sel + 1'b1;
    assign all_new   = (kept_all_reg == '1) ? kept_all_reg : kept_all_reg + 1'b1;

    // statistics operands
    assign av       = (kept_p_reg != '0) && (kept_t_reg != '0);
    assign pv       = (kept_all_reg >= 32'd3);
    assign span     = (34'(last_two0_reg) + 34'(last_two1_reg))
                    - (34'(first_two0_reg) + 34'(first_two1_reg));
    assign span_pos = span[33] ? '0 : span[32:0];

    always_comb
    begin
        case (state_reg)
            ST_DIV_P:
            begin
                div_num = peak_sum_reg;
                div_den = kept_p_reg;
            end
            ST_DIV_T:
            begin
                div_num = trough_sum_reg;
                div_den = kept_t_reg;
            end
            ST_DIV_S:
            begin
                div_num = {15'd0, span_pos, 16'd0};
                div_den = kept_all_reg - 32'd2;
            end
            default:
            begin
                div_num = '0;
                div_den = 32'd1;
            end
        endcase
    end

    swptd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // half the mean difference, truncated toward zero
    assign mean_diff = qp_reg - qt_reg;
    assign mean_adj  = mean_diff + 64'(mean_diff[63]);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == swptd_pkg::REG_WINDOW_STEPS) ? 32'(window_steps_reg) : 32'd0;

    // sequencer, channel state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_steps_reg <= swptd_pkg::WINDOW_STEPS_RST;
            head_reg         <= '0;
            fill_reg         <= '0;
            step_count_reg   <= '0;
            have_crit_reg    <= 1'b0;
            last_is_peak_reg <= 1'b0;
            last_value_reg   <= '0;
            last_two0_reg    <= '0;
            last_two1_reg    <= '0;
            first_two0_reg   <= '0;
            first_two1_reg   <= '0;
            peak_sum_reg     <= '0;
            trough_sum_reg   <= '0;
            kept_p_reg       <= '0;
            kept_t_reg       <= '0;
            kept_all_reg     <= '0;
            finish_reg       <= 1'b0;
            lag_reg          <= '0;
            time_reg         <= '0;
            qp_reg           <= '0;
            qt_reg           <= '0;
            period_q_reg     <= '0;
            div_go_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            kind_reg         <= '0;
            crit_step_reg    <= '0;
            crit_value_reg   <= '0;
            amplitude_reg    <= '0;
            period_reg       <= '0;
            amp_valid_reg    <= 1'b0;
            period_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write && (paddr == swptd_pkg::REG_WINDOW_STEPS))
            begin
                window_steps_reg <= pwdata[6:0];
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (op == swptd_pkg::OP_PUSH)
                        begin
                            head_reg       <= head_next;
                            fill_reg       <= fill_push;
                            step_count_reg <= step_count_reg + 1'b1;
                            time_reg       <= 33'(step_count_reg);
                            lag_reg        <= '0;
                            finish_reg     <= 1'b0;
                            if (fill_push >= half)
                            begin
                                state_reg <= ST_SCAN_START;
                            end
                        end
                        else
                        begin
                            fill_reg   <= fill_clip;
                            time_reg   <= 33'(step_count_reg);
                            lag_reg    <= (FillW + 1)'(1);
                            finish_reg <= 1'b1;
                            state_reg  <= ST_DRAIN;
                        end
                    end
                end

                ST_SCAN_START:
                begin
                    state_reg <= ST_SCAN_WAIT;
                end

                ST_SCAN_WAIT:
                begin
                    if (scan_res.done)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end

                ST_EVAL:
                begin
                    if (out_free)
                    begin
                        if (do_emit)
                        begin
                            if (is_peak)
                            begin
                                peak_sum_reg <= sum_new;
                            end
                            else
                            begin
                                trough_sum_reg <= sum_new;
                            end
                            last_value_reg <= cval;
                            last_two1_reg  <= stp;
                            if (same_kind)
                            begin
                                if (kept_all_reg == 32'd1)
                                begin
                                    first_two0_reg <= stp;
                                end
                                if (kept_all_reg == 32'd2)
                                begin
                                    first_two1_reg <= stp;
                                end
                                kind_reg <= is_peak ? swptd_pkg::KIND_PEAK_REPL
                                                    : swptd_pkg::KIND_TROUGH_REPL;
                            end
                            else
                            begin
                                if (is_peak)
                                begin
                                    kept_p_reg <= cnt_new;
                                end
                                else
                                begin
                                    kept_t_reg <= cnt_new;
                                end
                                if (kept_all_reg == 32'd0)
                                begin
                                    first_two0_reg <= stp;
                                end
                                if (kept_all_reg == 32'd1)
                                begin
                                    first_two1_reg <= stp;
                                end
                                kept_all_reg     <= all_new;
                                last_two0_reg    <= last_two1_reg;
                                have_crit_reg    <= 1'b1;
                                last_is_peak_reg <= is_peak;
                                kind_reg <= is_peak ? swptd_pkg::KIND_PEAK
                                                    : swptd_pkg::KIND_TROUGH;
                            end
                            out_valid_reg    <= 1'b1;
                            crit_step_reg    <= stp;
                            crit_value_reg   <= cval;
                            amplitude_reg    <= '0;
                            period_reg       <= '0;
                            amp_valid_reg    <= 1'b0;
                            period_valid_reg <= 1'b0;
                            last_reg         <= !finish_reg;
                        end
                        if (finish_reg)
                        begin
                            time_reg  <= time_reg + 1'b1;
                            lag_reg   <= lag_reg + 1'b1;
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_DRAIN:
                begin
                    if ((fill_reg >= half) && (fill_reg != '0))
                    begin
                        fill_reg <= fill_m1;
                        if (fill_m1 != '0)
                        begin
                            state_reg <= ST_SCAN_START;
                        end
                        else
                        begin
                            time_reg <= time_reg + 1'b1;
                            lag_reg  <= lag_reg + 1'b1;
                        end
                    end
                    else if (av)
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIV_P;
                    end
                    else if (pv)
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIV_S;
                    end
                    else
                    begin
                        state_reg <= ST_STATS;
                    end
                end

                ST_DIV_P:
                begin
                    if (div_done)
                    begin
                        qp_reg     <= div_q;
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIV_T;
                    end
                end

                ST_DIV_T:
                begin
                    if (div_done)
                    begin
                        qt_reg <= div_q;
                        if (pv)
                        begin
                            div_go_reg <= 1'b1;
                            state_reg  <= ST_DIV_S;
                        end
                        else
                        begin
                            state_reg <= ST_STATS;
                        end
                    end
                end

                ST_DIV_S:
                begin
                    if (div_done)
                    begin
                        // held aside so a waiting result keeps its payload
                        period_q_reg <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
                        state_reg    <= ST_STATS;
                    end
                end

                ST_STATS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        kind_reg         <= swptd_pkg::KIND_STATS;
                        crit_step_reg    <= '0;
                        crit_value_reg   <= '0;
                        amplitude_reg    <= av ? mean_adj[32:1] : 32'd0;
                        period_reg       <= pv ? period_q_reg : 32'd0;
                        amp_valid_reg    <= av;
                        period_valid_reg <= pv;
                        last_reg         <= 1'b1;
                        // clear the channel, the register keeps its value
                        head_reg         <= '0;
                        fill_reg         <= '0;
                        step_count_reg   <= '0;
                        have_crit_reg    <= 1'b0;
                        last_is_peak_reg <= 1'b0;
                        last_value_reg   <= '0;
                        last_two0_reg    <= '0;
                        last_two1_reg    <= '0;
                        first_two0_reg   <= '0;
                        first_two1_reg   <= '0;
                        peak_sum_reg     <= '0;
                        trough_sum_reg   <= '0;
                        kept_p_reg       <= '0;
                        kept_t_reg       <= '0;
                        kept_all_reg     <= '0;
                        finish_reg       <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign crit_step    = crit_step_reg;
    assign crit_value   = crit_value_reg;
    assign amplitude    = amplitude_reg;
    assign period       = period_reg;
    assign amp_valid    = amp_valid_reg;
    assign period_valid = period_valid_reg;
    assign last         = last_reg;

`include "sliding_window_peak_trough_detector_assert.svh"

    `SWPTD_ASSERT_SAME(a_scan_done_in_wait, scan_res.done, state_reg == ST_SCAN_WAIT, "scan finished outside its wait state")
    `SWPTD_ASSERT_SAME(a_div_done_in_div, div_done, state_reg == ST_DIV_P || state_reg == ST_DIV_T || state_reg == ST_DIV_S, "division finished outside a division state")
    `SWPTD_ASSERT_NEXT(a_push_counts_step, in_xfer && op == swptd_pkg::OP_PUSH, step_count_reg == $past(step_count_reg) + 32'd1, "push transfer did not advance the step count")
    `SWPTD_ASSERT_SAME(a_fill_bounded, 1'b1, 32'(fill_reg) <= 32'(MAX_WINDOW), "window fill beyond its largest length")

endmodule
